// ===== hdl/mck_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse keyer package
// Shared types, constants and code tables of the Morse character keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam logic [7:0] EndMark    = 8'h80;
  localparam logic [7:0] TableFirst = 8'd44;
  localparam logic [7:0] TableLast  = 8'd90;
  localparam logic [7:0] LowerFirst = 8'd97;
  localparam logic [7:0] LowerLast  = 8'd122;
  localparam logic [7:0] CaseOffset = 8'd32;
  localparam logic [7:0] SpaceCode  = 8'd32;

  localparam logic [5:0] SpeedMin = 6'd5;
  localparam logic [5:0] SpeedMax = 6'd50;

  localparam logic [2:0] MaxElems = 3'd6;

  localparam logic [2:0] UnitsDot    = 3'd1;
  localparam logic [2:0] UnitsDash   = 3'd3;
  localparam logic [2:0] UnitsGap    = 3'd1;
  localparam logic [2:0] UnitsLetter = 3'd2;
  localparam logic [2:0] UnitsWord   = 3'd7;
  localparam logic [2:0] UnitsSpace  = 3'd7;
  localparam logic [2:0] UnitsErr    = 3'd5;

  // 120 / 15
  localparam logic [4:0] ResetTicks = 5'd8;

  typedef struct packed {
    logic [7:0] code;
    logic       lead;
    logic       lead_long;
    logic       err;
    logic       word_end;
  } mck_desc_t;

  function automatic logic [7:0] morse_code(input logic [5:0] idx);
    case (idx)
      6'd0:  return 8'hCE;
      6'd1:  return 8'h86;
      6'd2:  return 8'h56;
      6'd3:  return 8'h94;
      6'd4:  return 8'hFC;
      6'd5:  return 8'h7C;
      6'd6:  return 8'h3C;
      6'd7:  return 8'h1C;
      6'd8:  return 8'h0C;
      6'd9:  return 8'h04;
      6'd10: return 8'h84;
      6'd11: return 8'hC4;
      6'd12: return 8'hE4;
      6'd13: return 8'hF4;
      6'd14: return 8'hE2;
      6'd15: return 8'hAA;
      6'd16: return 8'h80;
      6'd17: return 8'h8C;
      6'd18: return 8'h80;
      6'd19: return 8'h32;
      6'd20: return 8'h80;
      6'd21: return 8'h60;
      6'd22: return 8'h88;
      6'd23: return 8'hA8;
      6'd24: return 8'h90;
      6'd25: return 8'h40;
      6'd26: return 8'h28;
      6'd27: return 8'hD0;
      6'd28: return 8'h08;
      6'd29: return 8'h20;
      6'd30: return 8'h78;
      6'd31: return 8'hB0;
      6'd32: return 8'h48;
      6'd33: return 8'hE0;
      6'd34: return 8'hA0;
      6'd35: return 8'hF0;
      6'd36: return 8'h68;
      6'd37: return 8'hD8;
      6'd38: return 8'h50;
      6'd39: return 8'h10;
      6'd40: return 8'hC0;
      6'd41: return 8'h30;
      6'd42: return 8'h18;
      6'd43: return 8'h70;
      6'd44: return 8'h98;
      6'd45: return 8'hB8;
      6'd46: return 8'hC8;
      default: return EndMark;
    endcase
  endfunction

  // 120 / speed, integer
  function automatic logic [4:0] ticks_per_unit(input logic [5:0] speed);
    case (speed) inside
      6'd5:            return 5'd24;
      6'd6:            return 5'd20;
      6'd7:            return 5'd17;
      6'd8:            return 5'd15;
      6'd9:            return 5'd13;
      6'd10:           return 5'd12;
      [6'd11:6'd12]:   return 5'd10;
      6'd13:           return 5'd9;
      [6'd14:6'd15]:   return 5'd8;
      [6'd16:6'd17]:   return 5'd7;
      [6'd18:6'd20]:   return 5'd6;
      [6'd21:6'd24]:   return 5'd5;
      [6'd25:6'd30]:   return 5'd4;
      [6'd31:6'd40]:   return 5'd3;
      [6'd41:6'd50]:   return 5'd2;
      default:         return ResetTicks;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hdl/morse_character_keyer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse character keyer core
// Turns ASCII characters into timed key-down / key-up intervals.
//
// Input channel: char_code_i, word_end_i with in_valid_i / in_stall_o; one
// transaction per character. Output channel: key_down_o, duration_ticks_o,
// status_o, last_o with out_valid_o / out_stall_i; one transaction per key
// interval, last_o marks the final interval of a character.
// The front end classifies a character in the accept cycle into a two-entry
// descriptor queue; the sequencer emits one interval per cycle while a
// descriptor is queued and the output is not stalled, which sets the
// throughput. A character takes 1 to 14 intervals; its descriptor is
// registered in the queue, then each interval in the output register.
// cfg_we_i / cfg_wdata_i load the speed in words per minute; values outside
// 5..50 are ignored. Write only while the block is idle.
// Reset empties the queue and output register and sets 15 wpm.
// A stalled receiver holds the output register; the queue fills, then
// in_stall_o rises.
// ----------------------------------------------------------------------------
module morse_character_keyer_core import mck_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [5:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       word_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            key_down_o,
  output logic [7:0]      duration_ticks_o,
  output logic            status_o,
  output logic            last_o
);

  logic [4:0] ticks_q;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  mck_desc_t  push_desc;
  mck_desc_t  head_desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= ResetTicks;
    end else if (cfg_we_i && cfg_wdata_i >= SpeedMin && cfg_wdata_i <= SpeedMax) begin
      ticks_q <= ticks_per_unit(cfg_wdata_i);
    end
  end

  mck_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .word_end_i  (word_end_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_desc_o    (push_desc)
  );

  mck_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_desc)
  );

  mck_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ticks_i          (ticks_q),
    .q_valid_i        (q_valid),
    .q_head_i         (head_desc),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .key_down_o       (key_down_o),
    .duration_ticks_o (duration_ticks_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

// ===== hdl/mck_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse keyer front end
// Folds case and classifies each character into a keying descriptor.
// ----------------------------------------------------------------------------
module mck_front import mck_pkg::*; (
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       word_end_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output mck_desc_t       q_desc_o
);

  logic [7:0] c_fold;
  logic [7:0] c_off;

  always_comb begin
    c_fold = char_code_i;
    if (char_code_i >= LowerFirst && char_code_i <= LowerLast) begin
      c_fold = char_code_i - CaseOffset;
    end
    c_off = c_fold - TableFirst;

    q_desc_o.word_end  = word_end_i;
    q_desc_o.code      = EndMark;
    q_desc_o.lead      = 1'b0;
    q_desc_o.lead_long = 1'b0;
    q_desc_o.err       = 1'b0;
    if (c_fold == SpaceCode) begin
      q_desc_o.lead      = 1'b1;
      q_desc_o.lead_long = 1'b1;
    end else if (c_fold < TableFirst || c_fold > TableLast) begin
      q_desc_o.lead = 1'b1;
      q_desc_o.err  = 1'b1;
    end else begin
      q_desc_o.code = morse_code(c_off[5:0]);
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

endmodule
`default_nettype wire

// ===== hdl/mck_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse keyer descriptor queue
// Two-entry queue between the front end and the keying sequencer.
// ----------------------------------------------------------------------------
module mck_queue import mck_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire mck_desc_t push_desc_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output mck_desc_t      head_o
);

  mck_desc_t  mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign full_o  = count_q[1];
  assign valid_o = count_q != 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

// ===== hdl/mck_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse keyer sequencer
// Walks the head descriptor and emits one key interval per cycle while one is queued and the output is not stalled.
// ----------------------------------------------------------------------------
module mck_back import mck_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [4:0] ticks_i,
  input  wire logic       q_valid_i,
  input  wire mck_desc_t  q_head_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            key_down_o,
  output logic [7:0]      duration_ticks_o,
  output logic            status_o,
  output logic            last_o
);

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_DOWN,
    PH_UP,
    PH_LETTER,
    PH_WORD
  } phase_e;

  phase_e     phase_q, phase_d, eff;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] shifted, shifted_nxt;
  logic [2:0] units;
  logic       down;
  logic       last;
  logic       fire;
  logic       out_valid_q;
  logic       key_down_q;
  logic [7:0] duration_q;
  logic       status_q;
  logic       last_q;

  always_comb begin
    shifted     = q_head_i.code << cnt_q;
    shifted_nxt = q_head_i.code << (cnt_q + 3'd1);
    eff = phase_q;
    if (phase_q == PH_START) begin
      if (q_head_i.lead)                eff = PH_LEAD;
      else if (q_head_i.code != EndMark) eff = PH_DOWN;
      else                              eff = PH_LETTER;
    end

    units   = UnitsLetter;
    down    = 1'b0;
    last    = 1'b0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    case (eff)
      PH_LEAD: begin
        units   = q_head_i.lead_long ? UnitsSpace : UnitsErr;
        phase_d = PH_LETTER;
      end
      PH_DOWN: begin
        down    = 1'b1;
        units   = shifted[7] ? UnitsDash : UnitsDot;
        phase_d = PH_UP;
      end
      PH_UP: begin
        units   = UnitsGap;
        cnt_d   = cnt_q + 3'd1;
        phase_d = (shifted_nxt != EndMark && cnt_d < MaxElems) ? PH_DOWN : PH_LETTER;
      end
      PH_LETTER: begin
        units   = UnitsLetter;
        last    = ~q_head_i.word_end;
        phase_d = PH_WORD;
      end
      PH_WORD: begin
        units = UnitsWord;
        last  = 1'b1;
      end
      default: begin
        units = UnitsLetter;
      end
    endcase
    if (last) begin
      phase_d = PH_START;
      cnt_d   = 3'd0;
    end
  end

  assign fire    = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign q_pop_o = fire & last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
      key_down_q  <= 1'b0;
      duration_q  <= 8'd0;
      status_q    <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (fire) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
        key_down_q  <= down;
        duration_q  <= 8'(units) * 8'(ticks_i);
        status_q    <= q_head_i.err;
        last_q      <= last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign key_down_o       = key_down_q;
  assign duration_ticks_o = duration_q;
  assign status_o         = status_q;
  assign last_o           = last_q;

`ifndef SYNTH
  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (phase_q == PH_START && cnt_q == 3'd0))
    else $error("sequencer did not restart after final interval");

  a_dur_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duration_ticks_o != 8'd0)
    else $error("zero-length key interval");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxElems)
    else $error("element count overrun");

  a_fire_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_START |-> q_valid_i)
    else $error("sequencer mid-character without a queued descriptor");
`endif

endmodule
`default_nettype wire

// ===== dv/mck_keying_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse keyer interval checker
// Watches the configuration port and both channels of the keyer core. For
// each accepted character it works out the key intervals the core must send
// and compares every accepted interval, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module mck_keying_checker import mck_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] char_code_i,
  input  logic       word_end_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       key_down_i,
  input  logic [7:0] duration_ticks_i,
  input  logic       status_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  localparam int         TickBase     = 120;
  localparam logic [5:0] ResetSpeed   = 6'd15;
  localparam int         PatternCount = 47;
  localparam int         MaxElemRuns  = 12;

  // entry 0 (code 0x2C) in the top byte
  localparam logic [PatternCount*8-1:0] PatternRom = {
    8'hCE, 8'h86, 8'h56, 8'h94,
    8'hFC, 8'h7C, 8'h3C, 8'h1C, 8'h0C, 8'h04, 8'h84, 8'hC4, 8'hE4, 8'hF4,
    8'hE2, 8'hAA, 8'h80, 8'h8C, 8'h80, 8'h32, 8'h80,
    8'h60, 8'h88, 8'hA8, 8'h90, 8'h40, 8'h28, 8'hD0, 8'h08, 8'h20, 8'h78,
    8'hB0, 8'h48, 8'hE0, 8'hA0, 8'hF0, 8'h68, 8'hD8, 8'h50, 8'h10, 8'hC0,
    8'h30, 8'h18, 8'h70, 8'h98, 8'hB8, 8'hC8
  };

  typedef struct packed {
    logic       key_down;
    logic [7:0] duration_ticks;
    logic       status;
    logic       last;
  } key_interval_t;

  key_interval_t pending_intervals[$];
  logic [5:0]    speed_wpm;
  int            fails;
  int            checked;

  function automatic key_interval_t make_interval(input logic down, input logic [2:0] units,
                                                  input int per);
    key_interval_t iv;
    iv.key_down       = down;
    iv.duration_ticks = 8'(int'(units) * per);
    iv.status         = 1'b0;
    iv.last           = 1'b0;
    return iv;
  endfunction

  task automatic predict_intervals(input logic [7:0] ch, input logic wend);
    logic [7:0]    c;
    logic [7:0]    pattern;
    logic          bad;
    int            per;
    int            idx;
    key_interval_t run[$];
    c   = ch;
    bad = 1'b0;
    per = TickBase / int'(speed_wpm);
    if (c >= LowerFirst && c <= LowerLast) c = c - CaseOffset;
    if (c == SpaceCode) begin
      run.push_back(make_interval(1'b0, UnitsSpace, per));
    end else if (c < TableFirst || c > TableLast) begin
      run.push_back(make_interval(1'b0, UnitsErr, per));
      bad = 1'b1;
    end else begin
      idx     = int'(c - TableFirst);
      pattern = PatternRom[(PatternCount - 1 - idx) * 8 +: 8];
      while (pattern != EndMark && run.size() < MaxElemRuns) begin
        run.push_back(make_interval(1'b1, pattern[7] ? UnitsDash : UnitsDot, per));
        run.push_back(make_interval(1'b0, UnitsGap, per));
        pattern = pattern << 1;
      end
    end
    run.push_back(make_interval(1'b0, UnitsLetter, per));
    if (wend) run.push_back(make_interval(1'b0, UnitsWord, per));
    foreach (run[i]) run[i].status = bad;
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) pending_intervals.push_back(run[i]);
  endtask

  initial begin
    fails   = 0;
    checked = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    key_interval_t want;
    if (!rst_ni) begin
      speed_wpm = ResetSpeed;
      pending_intervals.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
      checked_o    <= checked;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (pending_intervals.size() == 0) begin
          fails++;
          $error("unexpected interval: key_down %0b duration_ticks %0d status %0b last %0b",
                 key_down_i, duration_ticks_i, status_i, last_i);
        end else begin
          want = pending_intervals.pop_front();
          if (want.key_down !== key_down_i) begin
            fails++;
            $error("key_down: expected %0b, actual %0b", want.key_down, key_down_i);
          end
          if (want.duration_ticks !== duration_ticks_i) begin
            fails++;
            $error("duration_ticks: expected %0d, actual %0d", want.duration_ticks,
                   duration_ticks_i);
          end
          if (want.status !== status_i) begin
            fails++;
            $error("status: expected %0b, actual %0b", want.status, status_i);
          end
          if (want.last !== last_i) begin
            fails++;
            $error("last: expected %0b, actual %0b", want.last, last_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_intervals(char_code_i, word_end_i);
      if (cfg_we_i && cfg_wdata_i >= SpeedMin && cfg_wdata_i <= SpeedMax) begin
        speed_wpm = cfg_wdata_i;
      end
      pending_o    <= pending_intervals.size();
      fail_count_o <= fails;
      checked_o    <= checked;
    end
  end

endmodule

// ===== dv/morse_character_keyer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse keyer core testbench
// Sends directed and random characters at several keying speeds under three
// sender / receiver idling profiles and one long receiver hold-off; the
// interval checker predicts and compares every key interval.
// ----------------------------------------------------------------------------
module morse_character_keyer_core_tb import mck_pkg::*;;

  localparam int IdleLimit   = 2000;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 6;
  localparam int PhaseCount  = 6;
  localparam int PhaseChars  = 16;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [5:0] cfg_wdata_i = 6'd0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_code_i = 8'd0;
  logic       word_end_i  = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       key_down_o;
  logic [7:0] duration_ticks_o;
  logic       status_o;
  logic       last_o;

  int fail_count;
  int pending;
  int checked;

  int send_idle_pct = 13;
  int recv_idle_pct = 72;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int chars_sent    = 0;
  int speed_writes  = 0;

  morse_character_keyer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .word_end_i      (word_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .key_down_o      (key_down_o),
    .duration_ticks_o(duration_ticks_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  mck_keying_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .char_code_i     (char_code_i),
    .word_end_i      (word_end_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .key_down_i      (key_down_o),
    .duration_ticks_i(duration_ticks_o),
    .status_i        (status_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, or a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IdleLimit) begin
      $display("morse_character_keyer_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // returns in the cycle of the transaction, valid still high
  task automatic send_char(input logic [7:0] c, input logic wend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    word_end_i  <= wend;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_speed(input logic [5:0] wpm);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= wpm;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    speed_writes++;
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    case ($urandom_range(4))
      0:       return 8'($urandom_range(65, 90));
      1:       return 8'($urandom_range(97, 122));
      2:       return 8'($urandom_range(44, 64));
      3:       return SpaceCode;
      default: return 8'($urandom_range(65, 122));
    endcase
  endfunction

  task automatic set_idling(input int snd, input int rcv);
    send_idle_pct  = snd;
    recv_idle_pct <= rcv;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset speed
    send_char(8'h41, 1'b0);
    send_char(8'h7A, 1'b0);
    send_char(8'h61, 1'b1);
    send_char(8'h5A, 1'b0);
    send_char(8'h2C, 1'b0);
    send_char(8'h30, 1'b0);
    send_char(8'h35, 1'b0);
    send_char(8'h3F, 1'b1);
    send_char(8'h3C, 1'b0);
    send_char(8'h3E, 1'b0);
    send_char(8'h40, 1'b1);
    send_char(SpaceCode, 1'b0);
    send_char(SpaceCode, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'h2B, 1'b1);
    send_char(8'h5B, 1'b0);
    send_char(8'h60, 1'b0);
    send_char(8'h7B, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h80, 1'b0);
    send_char(8'h45, 1'b0);
    send_char(8'h54, 1'b1);

    for (int p = 0; p < PhaseCount; p++) begin
      wait_drained();
      case (p)
        0: write_speed(SpeedMax);
        1: begin
          write_speed(SpeedMin);
          write_speed(6'd4);
        end
        2: write_speed(6'd51);
        3: begin
          write_speed(6'd0);
          write_speed(6'd17);
        end
        4: write_speed(6'd63);
        default: write_speed(6'($urandom_range(SpeedMin, SpeedMax)));
      endcase
      if (p < 2) set_idling(13, 72);
      else if (p < 4) set_idling(72, 13);
      else set_idling(0, 0);
      if (p == 4) hold_req <= hold_req + 1;
      for (int i = 0; i < PhaseChars; i++) send_char(pick_char(), ($urandom_range(3) == 0));
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("run covered %0d characters and %0d key intervals, %0d speed writes",
             chars_sent, checked, speed_writes);
    $display("three idling profiles plus a %0d-cycle receiver hold-off", HoldCycles);
    if (fail_count == 0) begin
      $display("morse_character_keyer_core: match");
    end else begin
      $display("morse_character_keyer_core: mismatch");
    end
    $finish;
  end

endmodule
